// ----- rtl/fbpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants, codes and controller/datapath interface types for the
// fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int POOLS           = 4;
    localparam int BLOCKS_PER_POOL = 64;

    localparam int POOL_W  = $clog2(POOLS);
    localparam int IDX_W   = $clog2(BLOCKS_PER_POOL);
    localparam int CNT_W   = 7;
    localparam int SIZE_W  = 16;
    localparam int BYTES_W = 24;
    localparam int FRAG_W  = 7;
    localparam int PROD_W  = SIZE_W + CNT_W;
    localparam int GRP_W   = 8;
    localparam int NGRP    = BLOCKS_PER_POOL / GRP_W;

    localparam int ADDR_W     = $clog2(2 * POOLS) + 2;
    localparam int DATA_W     = 32;
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = 3;

    localparam logic [FRAG_W-1:0] FRAG_FULL = FRAG_W'(100);

    // request codes
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_STATS = 2'd2;

    // register select within a pool pair
    localparam logic REG_SIZE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_ALLOC_OK = 3'd0,
        ST_NO_BLOCK = 3'd1,
        ST_FREED    = 3'd2,
        ST_FREE_IGN = 3'd3,
        ST_STATS    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_FREE,
        S_STATS,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic    take_req;
        logic    step_pool;
        logic    grant;
        logic    free_commit;
        logic    stats_acc;
        logic    set_res;
        t_status res_code;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic last_pool;
        logic free_ok;
        logic out_room;
    } t_sts;

endpackage

// ----- rtl/fbpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencer: walks pools for allocate and statistics requests,
// checks a free request, and hands the result to the output register.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_in_type,
    output logic          o_in_ready,
    input  fbpa_pkg::t_sts i_sts,
    output fbpa_pkg::t_cmd o_cmd
);
    import fbpa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_type)
                        REQ_ALLOC: n_state = S_ALLOC;
                        REQ_FREE:  n_state = S_FREE;
                        default:   n_state = S_STATS;
                    endcase
                end
            end
            S_ALLOC: begin
                if (i_sts.hit || i_sts.last_pool) n_state = S_FINISH;
            end
            S_FREE: begin
                n_state = S_FINISH;
            end
            S_STATS: begin
                if (i_sts.last_pool) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_room) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.res_code = ST_NO_BLOCK;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.take_req = i_in_valid;
            end
            S_ALLOC: begin
                if (i_sts.hit) begin
                    o_cmd.grant    = 1'b1;
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_ALLOC_OK;
                end else if (i_sts.last_pool) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_NO_BLOCK;
                end else begin
                    o_cmd.step_pool = 1'b1;
                end
            end
            S_FREE: begin
                o_cmd.set_res     = 1'b1;
                o_cmd.free_commit = i_sts.free_ok;
                o_cmd.res_code    = i_sts.free_ok ? ST_FREED : ST_FREE_IGN;
            end
            S_STATS: begin
                o_cmd.stats_acc = 1'b1;
                o_cmd.step_pool = 1'b1;
                if (i_sts.last_pool) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = ST_STATS;
                end
            end
            S_FINISH: begin
                o_cmd.load_out = i_sts.out_room;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/fbpa_dp.sv -----
// ----------------------------------------------------------------------------
// fbpa_dp
// Pool registers, in-use bitmaps, used counts, statistics accumulators and
// the output register.
// ----------------------------------------------------------------------------
module fbpa_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fbpa_pkg::t_cmd                    i_cmd,
    output fbpa_pkg::t_sts                    o_sts,
    input  logic [fbpa_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic [fbpa_pkg::IN_USER_W-1:0]    i_in_user,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [fbpa_pkg::OUT_DATA_W-1:0]   o_out_data,
    output logic [fbpa_pkg::OUT_USER_W-1:0]   o_out_user,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [fbpa_pkg::ADDR_W-1:0]       i_paddr,
    input  logic [fbpa_pkg::DATA_W-1:0]       i_pwdata,
    output logic [fbpa_pkg::DATA_W-1:0]       o_prdata
);
    import fbpa_pkg::*;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        return (c > CNT_W'(BLOCKS_PER_POOL)) ? CNT_W'(BLOCKS_PER_POOL) : c;
    endfunction

    // lowest clear bit, group first then bit within group
    function automatic logic [IDX_W-1:0] low_zero(input logic [BLOCKS_PER_POOL-1:0] m);
        logic [IDX_W-1:0] grp;
        logic [IDX_W-1:0] bit_sel;
        logic [GRP_W-1:0] row;
        grp     = '0;
        bit_sel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (!(&m[g*GRP_W +: GRP_W])) grp = IDX_W'(g);
        end
        row = m[grp*GRP_W +: GRP_W];
        for (int b = GRP_W - 1; b >= 0; b--) begin
            if (!row[b]) bit_sel = IDX_W'(b);
        end
        return IDX_W'(grp * GRP_W) + bit_sel;
    endfunction

    logic [SIZE_W-1:0]          r_size  [POOLS];
    logic [CNT_W-1:0]           r_count [POOLS];
    logic [BLOCKS_PER_POOL-1:0] r_map   [POOLS];
    logic [CNT_W-1:0]           r_used  [POOLS];

    logic [SIZE_W-1:0]  r_req_size;
    logic [IDX_W-1:0]   r_rel_idx;
    logic [POOL_W-1:0]  r_pool;
    t_status            r_res_status;
    logic [POOL_W-1:0]  r_res_gpool;
    logic [IDX_W-1:0]   r_res_gidx;
    logic [BYTES_W-1:0] r_acc_total;
    logic [BYTES_W-1:0] r_acc_used;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic                  cfg_we;
    logic [POOL_W-1:0]     cfg_pool;
    logic                  cfg_sel;
    logic [SIZE_W-1:0]     cur_size;
    logic [CNT_W-1:0]      cur_eff;
    logic [CNT_W-1:0]      cur_used;
    logic [BLOCKS_PER_POOL-1:0] cur_map;
    logic [IDX_W-1:0]      gidx;
    logic [PROD_W-1:0]     prod_total;
    logic [PROD_W-1:0]     prod_used;
    logic [BYTES_W-1:0]    free_bytes;
    logic [FRAG_W-1:0]     frag;

    assign cfg_we   = i_psel && i_penable && i_pwrite;
    assign cfg_pool = i_paddr[ADDR_W-1:3];
    assign cfg_sel  = i_paddr[2];

    always_comb begin
        o_prdata = '0;
        unique case (cfg_sel)
            REG_SIZE:  o_prdata = DATA_W'(r_size[i_paddr[ADDR_W-1:3]]);
            REG_COUNT: o_prdata = DATA_W'(r_count[i_paddr[ADDR_W-1:3]]);
            default:   o_prdata = '0;
        endcase
    end

    assign cur_size = r_size[r_pool];
    assign cur_eff  = eff_count(r_count[r_pool]);
    assign cur_used = r_used[r_pool];
    assign cur_map  = r_map[r_pool];
    assign gidx     = low_zero(cur_map);

    assign prod_total = cur_size * cur_eff;
    assign prod_used  = cur_size * cur_used;

    // free bytes equal total minus used, so the ratio is full or zero
    assign free_bytes = r_acc_total - r_acc_used;
    assign frag       = (free_bytes != '0) ? FRAG_FULL : '0;

    assign o_sts.hit       = (cur_size >= r_req_size) && (cur_used < cur_eff);
    assign o_sts.last_pool = (r_pool == POOL_W'(POOLS - 1));
    assign o_sts.free_ok   = ({1'b0, r_rel_idx} < cur_eff) && cur_map[r_rel_idx];
    assign o_sts.out_room  = !r_out_valid || i_out_ready;

    // pool setup and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < POOLS; p++) begin
                r_size[p]  <= '0;
                r_count[p] <= '0;
                r_map[p]   <= '0;
                r_used[p]  <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_sel == REG_SIZE) begin
                r_size[cfg_pool] <= i_pwdata[SIZE_W-1:0];
            end else begin
                r_count[cfg_pool] <= i_pwdata[CNT_W-1:0];
            end
            r_map[cfg_pool]  <= '0;
            r_used[cfg_pool] <= '0;
        end else if (i_cmd.grant) begin
            r_map[r_pool][gidx] <= 1'b1;
            r_used[r_pool]      <= r_used[r_pool] + 1'b1;
        end else if (i_cmd.free_commit) begin
            r_map[r_pool][r_rel_idx] <= 1'b0;
            r_used[r_pool]           <= r_used[r_pool] - 1'b1;
        end
    end

    // request and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_req_size  <= i_in_data[SIZE_W-1:0];
            r_rel_idx   <= i_in_data[SIZE_W+POOL_W +: IDX_W];
            r_pool      <= (i_in_user == REQ_FREE) ? i_in_data[SIZE_W +: POOL_W] : '0;
            r_res_gpool <= '0;
            r_res_gidx  <= '0;
            r_acc_total <= '0;
            r_acc_used  <= '0;
        end else begin
            if (i_cmd.step_pool) r_pool <= r_pool + 1'b1;
            if (i_cmd.grant) begin
                r_res_gpool <= r_pool;
                r_res_gidx  <= gidx;
            end
            if (i_cmd.stats_acc) begin
                r_acc_total <= r_acc_total + BYTES_W'(prod_total);
                r_acc_used  <= r_acc_used + BYTES_W'(prod_used);
            end
        end
        if (i_cmd.set_res) r_res_status <= i_cmd.res_code;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_user <= OUT_USER_W'(r_res_status);
            r_out_data <= {1'b0, frag, free_bytes, r_acc_used, r_acc_total,
                           r_res_gidx, r_res_gpool};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

// ----- rtl/fixed_block_pool_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// Allocator over four pools of equal-size blocks with a request stream,
// a result stream and an APB register port.
//
// requests enter on s_axis: tuser is the request kind (allocate, free,
// statistics), tdata carries size, release pool and release block.
// every request yields one item on m_axis: tuser is the status, tdata
// carries the granted pool and block or the byte statistics.
// pool registers are to be written over APB only while no request is in flight;
// the block itself does not enforce it. a write to either register of a pool frees all its blocks.
// allocate probes the pools in order until one has a large enough free
// block, free checks the named pool and block, statistics walks all pools
// through the size by count multipliers. one request is worked at a time
// and the next one is taken the cycle after the result is loaded.
// a finished result sits in the output register; the next request is taken
// while it waits, and work stalls in its last step until the register frees.
// reset clears all pool registers, in-use bitmaps and counts at once.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // req_size[15:0], release_pool[17:16], release_index[23:18]
    input  logic [fbpa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type[1:0]
    input  logic [fbpa_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // grant_pool[1:0], grant_index[7:2], total_bytes[31:8], used_bytes[55:32],
    // free_bytes[79:56], fragmentation[86:80], zero pad[87]
    output logic [fbpa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status[2:0]
    output logic [fbpa_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fbpa_pkg::ADDR_W-1:0]       paddr,
    input  logic [fbpa_pkg::DATA_W-1:0]       pwdata,
    output logic [fbpa_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import fbpa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign pready = 1'b1;

    fbpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_type  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fbpa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_prdata    (prdata)
    );

endmodule

// ----- rtl/fbpa_checker.sv -----
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks on the result stream of the allocator, bound to the
// top level.
// ----------------------------------------------------------------------------
module fbpa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [fbpa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic [fbpa_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
    import fbpa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != OUT_USER_W'(ST_ALLOC_OK)) |->
            m_axis_tdata[7:0] == 8'd0)
        else $error("grant fields set on a non-grant result");

    a_stats_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != OUT_USER_W'(ST_STATS)) |->
            m_axis_tdata[87:8] == 80'd0)
        else $error("statistics fields set on a non-statistics result");

    a_free_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == OUT_USER_W'(ST_STATS)) |->
            m_axis_tdata[79:56] == 24'(m_axis_tdata[31:8] - m_axis_tdata[55:32]))
        else $error("free bytes differ from total minus used");

    a_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == OUT_USER_W'(ST_STATS)) |->
            ((m_axis_tdata[79:56] != 24'd0) && (m_axis_tdata[86:80] == FRAG_FULL)) ||
            ((m_axis_tdata[79:56] == 24'd0) && (m_axis_tdata[86:80] == 7'd0)))
        else $error("fragmentation figure inconsistent with free bytes");

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (.*);
